// ----- rtl/core/jdd_pkg.sv -----
// ----------------------------------------------------------------------------
// Joystick direction debouncer package
// Shared types, register codes, symbol and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package jdd_pkg;

  // History depth in slots, and the number of slots shown on the result.
  localparam int HISTORY_DEPTH = 5;
  localparam int REPORT_SLOTS  = 5;
  localparam int HIST_SLOTS    = (HISTORY_DEPTH > REPORT_SLOTS) ? HISTORY_DEPTH : REPORT_SLOTS;

  localparam int SAMPLE_W = 12;
  localparam int TICKS_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_W-1:0] RIGHT_THR_RST   = 12'd4050;
  localparam logic [SAMPLE_W-1:0] LEFT_THR_RST    = 12'd2000;
  localparam logic [TICKS_W-1:0]  CONFIRM_RST     = 16'd1;
  localparam logic [TICKS_W-1:0]  NEUTRAL_CFM_RST = 16'd20;
  localparam logic [TICKS_W-1:0]  HOLDOFF_RST     = 16'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT_THR   = 3'd0,
    CFG_LEFT_THR    = 3'd1,
    CFG_CONFIRM     = 3'd2,
    CFG_NEUTRAL_CFM = 3'd3,
    CFG_HOLDOFF     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SYM_RIGHT   = 2'd0,
    SYM_LEFT    = 2'd1,
    SYM_NEUTRAL = 2'd2,
    SYM_ATTACK  = 2'd3
  } sym_t;

  typedef enum logic [3:0] {
    ST_RIGHT        = 4'd0,
    ST_RIGHT_HELD   = 4'd1,
    ST_LEFT         = 4'd2,
    ST_LEFT_HELD    = 4'd3,
    ST_NEUTRAL_HELD = 4'd4,
    ST_NEUTRAL      = 4'd5,
    ST_DEBOUNCE     = 4'd6,
    ST_ATTACK       = 4'd7,
    ST_ATTACK_HELD  = 4'd8,
    ST_EDGE         = 4'd9
  } state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] right_threshold;
    logic [SAMPLE_W-1:0] left_threshold;
    logic [TICKS_W-1:0]  confirm_ticks;
    logic [TICKS_W-1:0]  neutral_confirm_ticks;
    logic [TICKS_W-1:0]  release_holdoff_ticks;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                button;
  } in_item_t;

  typedef struct packed {
    logic       emit_valid;
    logic [1:0] emit_symbol;
    logic [1:0] hist_newest;
    logic [1:0] hist_second;
    logic [1:0] hist_third;
    logic [1:0] hist_fourth;
    logic [1:0] hist_oldest;
    logic [3:0] machine_state;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/jdd_classify.sv -----
// ----------------------------------------------------------------------------
// Sample classifier
// Sorts one tick into attack, right, left or neutral; the button wins.
// ----------------------------------------------------------------------------
`default_nettype none

module jdd_classify (
  input  jdd_pkg::in_item_t item,
  input  jdd_pkg::cfg_t     cfg,
  output jdd_pkg::sym_t     cls
);
  import jdd_pkg::*;

  // Right test before left, so right wins on overlapping thresholds
  always_comb begin
    if (item.button) begin
      cls = SYM_ATTACK;
    end else if (item.sample > cfg.right_threshold) begin
      cls = SYM_RIGHT;
    end else if (item.sample <= cfg.left_threshold) begin
      cls = SYM_LEFT;
    end else begin
      cls = SYM_NEUTRAL;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/jdd_fsm.sv -----
// ----------------------------------------------------------------------------
// Debounce state machine
// Confirms classes after a wait, pushes symbols into the history and
// handles the attack release hold-off. Advances once per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module jdd_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  jdd_pkg::sym_t      cls,
  input  jdd_pkg::cfg_t      cfg,
  output jdd_pkg::out_item_t result
);
  import jdd_pkg::*;

  state_t                     state;
  state_t                     state_next;
  sym_t                       candidate;
  sym_t                       candidate_next;
  logic [TICKS_W-1:0]         wait_count;
  logic [TICKS_W-1:0]         wait_count_next;
  logic [HIST_SLOTS-1:0][1:0] hist;
  logic [HIST_SLOTS-1:0][1:0] hist_next;
  logic [REPORT_SLOTS-1:0][1:0] shown;

  logic               push;
  sym_t               push_sym;
  logic [TICKS_W-1:0] wait_dec;
  logic [TICKS_W-1:0] wait_load;
  state_t             emit_state;

  assign wait_dec  = wait_count - TICKS_W'(1);
  assign wait_load = (cls == SYM_NEUTRAL) ? cfg.neutral_confirm_ticks : cfg.confirm_ticks;

  // Emit state that belongs to the current class
  always_comb begin
    case (cls)
      SYM_RIGHT:   emit_state = ST_RIGHT;
      SYM_LEFT:    emit_state = ST_LEFT;
      SYM_NEUTRAL: emit_state = ST_NEUTRAL;
      default:     emit_state = ST_ATTACK;
    endcase
  end

  // Next state, candidate and wait counter
  always_comb begin
    state_next      = state;
    candidate_next  = candidate;
    wait_count_next = wait_count;
    case (state)
      ST_RIGHT:   state_next = ST_RIGHT_HELD;
      ST_LEFT:    state_next = ST_LEFT_HELD;
      ST_NEUTRAL: state_next = ST_NEUTRAL_HELD;
      ST_ATTACK:  state_next = ST_ATTACK_HELD;
      ST_RIGHT_HELD: begin
        if (cls != SYM_RIGHT) begin
          state_next      = ST_DEBOUNCE;
          wait_count_next = '0;
        end
      end
      ST_LEFT_HELD: begin
        if (cls != SYM_LEFT) begin
          state_next      = ST_DEBOUNCE;
          wait_count_next = '0;
        end
      end
      ST_NEUTRAL_HELD: begin
        if (cls != SYM_NEUTRAL) begin
          state_next      = ST_DEBOUNCE;
          wait_count_next = '0;
        end
      end
      ST_ATTACK_HELD: begin
        if (cls != SYM_ATTACK) begin
          state_next      = ST_EDGE;
          wait_count_next = '0;
        end
      end
      ST_EDGE: begin
        // Latch the release decision on the first tick, then sit out the hold-off
        if (wait_count == '0) begin
          candidate_next  = cls;
          wait_count_next = cfg.release_holdoff_ticks;
        end else begin
          wait_count_next = wait_dec;
        end
        if (wait_count_next == '0) begin
          state_next = (candidate_next == SYM_ATTACK) ? ST_ATTACK_HELD : ST_DEBOUNCE;
        end
      end
      ST_DEBOUNCE: begin
        if (wait_count == '0) begin
          candidate_next = cls;
          if (wait_load == '0) begin
            state_next = emit_state;
          end else begin
            wait_count_next = wait_load;
          end
        end else begin
          wait_count_next = wait_dec;
          if (wait_dec == '0 && cls == candidate) begin
            state_next = emit_state;
          end
        end
      end
      default: begin
        state_next      = ST_DEBOUNCE;
        wait_count_next = '0;
      end
    endcase
  end

  // Symbol push from the emit states
  always_comb begin
    push     = 1'b0;
    push_sym = SYM_RIGHT;
    case (state)
      ST_RIGHT: begin
        push     = 1'b1;
        push_sym = SYM_RIGHT;
      end
      ST_LEFT: begin
        push     = 1'b1;
        push_sym = SYM_LEFT;
      end
      ST_NEUTRAL: begin
        push     = 1'b1;
        push_sym = SYM_NEUTRAL;
      end
      ST_ATTACK: begin
        push     = 1'b1;
        push_sym = SYM_ATTACK;
      end
      default: begin
        push     = 1'b0;
        push_sym = SYM_RIGHT;
      end
    endcase
  end

  // Shift the history toward the oldest slot on a push
  always_comb begin
    hist_next = hist;
    if (push) begin
      for (int i = HIST_SLOTS - 1; i > 0; i--) begin
        hist_next[i] = hist[i-1];
      end
      hist_next[0] = push_sym;
    end
  end

  // Slots past the history depth read as neutral
  always_comb begin
    for (int k = 0; k < REPORT_SLOTS; k++) begin
      shown[k] = (k < HISTORY_DEPTH) ? hist_next[k] : SYM_NEUTRAL;
    end
  end

  always_comb begin
    result.emit_valid    = push;
    result.emit_symbol   = push ? push_sym : SYM_RIGHT;
    result.hist_newest   = shown[0];
    result.hist_second   = shown[1];
    result.hist_third    = shown[2];
    result.hist_fourth   = shown[3];
    result.hist_oldest   = shown[4];
    result.machine_state = state_next;
  end

  // Advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_DEBOUNCE;
      candidate  <= SYM_RIGHT;
      wait_count <= '0;
      hist       <= {HIST_SLOTS{SYM_NEUTRAL}};
    end else if (step) begin
      state      <= state_next;
      candidate  <= candidate_next;
      wait_count <= wait_count_next;
      hist       <= hist_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/joystick_direction_debouncer_core.sv -----
// ----------------------------------------------------------------------------
// Joystick direction debouncer core
// Classifies joystick ticks, confirms them through a debounce machine and
// reports each tick's symbol push and five-slot history.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall   | in_item_t  (sample, button)
//   out     | output    | out_valid/out_stall | out_item_t (emit, history, state)
//   cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// One transaction per cycle unless a result is stalled; each result is
// registered on acceptance. The state machine update and the result register
// close in the same cycle, so throughput is set by that single logic pass.
// Reset clears the machine, the history (all neutral) and the registers to
// their defaults; no clearing pass. Input stalls only while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_direction_debouncer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  jdd_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output jdd_pkg::out_item_t                    out_data,
  input  logic                                  cfg_write,
  input  logic [jdd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jdd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import jdd_pkg::*;

  cfg_t      cfg;
  sym_t      cls;
  out_item_t result;
  logic      accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.right_threshold       <= RIGHT_THR_RST;
      cfg.left_threshold        <= LEFT_THR_RST;
      cfg.confirm_ticks         <= CONFIRM_RST;
      cfg.neutral_confirm_ticks <= NEUTRAL_CFM_RST;
      cfg.release_holdoff_ticks <= HOLDOFF_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RIGHT_THR:   cfg.right_threshold       <= cfg_data[SAMPLE_W-1:0];
        CFG_LEFT_THR:    cfg.left_threshold        <= cfg_data[SAMPLE_W-1:0];
        CFG_CONFIRM:     cfg.confirm_ticks         <= cfg_data[TICKS_W-1:0];
        CFG_NEUTRAL_CFM: cfg.neutral_confirm_ticks <= cfg_data[TICKS_W-1:0];
        CFG_HOLDOFF:     cfg.release_holdoff_ticks <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  jdd_classify u_classify (
    .item (in_data),
    .cfg  (cfg),
    .cls  (cls)
  );

  jdd_fsm u_fsm (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .cls    (cls),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_emit_to_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.emit_valid) |->
      (out_data.machine_state == ST_RIGHT_HELD || out_data.machine_state == ST_LEFT_HELD ||
       out_data.machine_state == ST_NEUTRAL_HELD || out_data.machine_state == ST_ATTACK_HELD))
    else $error("symbol push did not land in a pressed state");

  a_emit_is_newest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.emit_valid) |-> (out_data.hist_newest == out_data.emit_symbol))
    else $error("pushed symbol is not the newest history slot");

  a_no_emit_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.emit_valid) |-> (out_data.emit_symbol == SYM_RIGHT))
    else $error("symbol set without a push");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_joystick_direction_debouncer_core.sv -----
// ----------------------------------------------------------------------------
// Joystick direction debouncer core testbench
// Drives tick transactions (sample, button) with random idle and stall bursts,
// mirrors the debounce machine, symbol history and register file in a local
// predictor, and checks every output transaction against it. Register writes
// happen between phases while the core is idle, covering threshold
// extremes, overlapping thresholds, zero waits and long waits.
// ----------------------------------------------------------------------------
module tb_joystick_direction_debouncer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import jdd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTED   = 10;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int LONG_WAIT      = 30;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  joystick_direction_debouncer_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predictor copy of the registers and the debounce machine
  logic [SAMPLE_W-1:0] thr_right     = RIGHT_THR_RST;
  logic [SAMPLE_W-1:0] thr_left      = LEFT_THR_RST;
  logic [TICKS_W-1:0]  ticks_confirm = CONFIRM_RST;
  logic [TICKS_W-1:0]  ticks_neutral = NEUTRAL_CFM_RST;
  logic [TICKS_W-1:0]  ticks_holdoff = HOLDOFF_RST;

  state_t             dir_state     = ST_DEBOUNCE;
  sym_t               dir_candidate = SYM_RIGHT;
  logic [TICKS_W-1:0] dir_wait      = '0;
  sym_t               dir_hist [HIST_SLOTS];

  initial begin
    foreach (dir_hist[i]) dir_hist[i] = SYM_NEUTRAL;
  end

  // Stimulus and scoreboard bookkeeping
  in_item_t  pending_ticks [$];
  out_item_t expected_reports [$];
  int ticks_queued = 0;
  int ticks_taken  = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int in_gap       = 0;
  int stall_left   = 0;
  bit in_accept    = 1'b0;
  bit calm         = 1'b0;

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] d);
    case (cfg_reg_e'(idx))
      CFG_RIGHT_THR:   thr_right = d[SAMPLE_W-1:0];
      CFG_LEFT_THR:    thr_left = d[SAMPLE_W-1:0];
      CFG_CONFIRM:     ticks_confirm = d[TICKS_W-1:0];
      CFG_NEUTRAL_CFM: ticks_neutral = d[TICKS_W-1:0];
      CFG_HOLDOFF:     ticks_holdoff = d[TICKS_W-1:0];
      default: ;
    endcase
  endfunction

  // Button wins, then right, then left; right wins on overlapping thresholds
  function automatic sym_t classify_tick(in_item_t t);
    if (t.button) return SYM_ATTACK;
    if (t.sample > thr_right) return SYM_RIGHT;
    if (t.sample <= thr_left) return SYM_LEFT;
    return SYM_NEUTRAL;
  endfunction

  function automatic state_t confirm_state_of(sym_t c);
    case (c)
      SYM_RIGHT:   return ST_RIGHT;
      SYM_LEFT:    return ST_LEFT;
      SYM_NEUTRAL: return ST_NEUTRAL;
      default:     return ST_ATTACK;
    endcase
  endfunction

  function automatic logic [1:0] hist_slot(int k);
    return (k < HISTORY_DEPTH) ? dir_hist[k] : SYM_NEUTRAL;
  endfunction

  // Advance the machine by one tick and build the expected output transaction
  function automatic out_item_t advance_debouncer(in_item_t t);
    sym_t               cls;
    sym_t               own;
    logic [TICKS_W-1:0] hold;
    out_item_t          r;
    int                 i;
    cls = classify_tick(t);
    r = '0;
    case (dir_state)
      ST_RIGHT, ST_LEFT, ST_NEUTRAL, ST_ATTACK: begin
        case (dir_state)
          ST_RIGHT: begin
            own = SYM_RIGHT;
            dir_state = ST_RIGHT_HELD;
          end
          ST_LEFT: begin
            own = SYM_LEFT;
            dir_state = ST_LEFT_HELD;
          end
          ST_NEUTRAL: begin
            own = SYM_NEUTRAL;
            dir_state = ST_NEUTRAL_HELD;
          end
          default: begin
            own = SYM_ATTACK;
            dir_state = ST_ATTACK_HELD;
          end
        endcase
        // shift toward oldest, drop the oldest symbol
        for (i = HISTORY_DEPTH - 1; i > 0; i--) dir_hist[i] = dir_hist[i-1];
        dir_hist[0] = own;
        r.emit_valid  = 1'b1;
        r.emit_symbol = own;
      end
      ST_RIGHT_HELD, ST_LEFT_HELD, ST_NEUTRAL_HELD: begin
        own = (dir_state == ST_RIGHT_HELD) ? SYM_RIGHT :
              (dir_state == ST_LEFT_HELD) ? SYM_LEFT : SYM_NEUTRAL;
        if (cls != own) begin
          dir_state = ST_DEBOUNCE;
          dir_wait  = '0;
        end
      end
      ST_ATTACK_HELD: begin
        if (cls != SYM_ATTACK) begin
          dir_state = ST_EDGE;
          dir_wait  = '0;
        end
      end
      ST_EDGE: begin
        // first tick decides, the rest of the hold-off is ignored
        if (dir_wait == '0) begin
          dir_candidate = cls;
          dir_wait      = ticks_holdoff;
        end else begin
          dir_wait = dir_wait - 1'b1;
        end
        if (dir_wait == '0)
          dir_state = (dir_candidate == SYM_ATTACK) ? ST_ATTACK_HELD : ST_DEBOUNCE;
      end
      ST_DEBOUNCE: begin
        if (dir_wait == '0) begin
          hold = (cls == SYM_NEUTRAL) ? ticks_neutral : ticks_confirm;
          dir_candidate = cls;
          if (hold == '0) dir_state = confirm_state_of(cls);
          else dir_wait = hold;
        end else begin
          dir_wait = dir_wait - 1'b1;
          if (dir_wait == '0 && cls == dir_candidate) dir_state = confirm_state_of(cls);
        end
      end
      default: begin
        dir_state = ST_DEBOUNCE;
        dir_wait  = '0;
      end
    endcase
    r.hist_newest   = hist_slot(0);
    r.hist_second   = hist_slot(1);
    r.hist_third    = hist_slot(2);
    r.hist_fourth   = hist_slot(3);
    r.hist_oldest   = hist_slot(4);
    r.machine_state = dir_state;
    return r;
  endfunction

  function automatic string show(out_item_t r);
    return $sformatf("emit=%0b sym=%0d hist=%0d,%0d,%0d,%0d,%0d state=%0d",
                     r.emit_valid, r.emit_symbol, r.hist_newest, r.hist_second,
                     r.hist_third, r.hist_fourth, r.hist_oldest, r.machine_state);
  endfunction

  function automatic void queue_tick(logic [SAMPLE_W-1:0] s, logic b);
    in_item_t t;
    t.sample = s;
    t.button = b;
    pending_ticks.push_back(t);
    ticks_queued++;
  endfunction

  // Queue n ticks of one class with random content inside its range
  function automatic void add_run(sym_t c, int n);
    logic [SAMPLE_W-1:0] s;
    logic                b;
    repeat (n) begin
      s = SAMPLE_W'($urandom);
      b = 1'b0;
      case (c)
        SYM_ATTACK: b = 1'b1;
        SYM_RIGHT: begin
          if (thr_right != SAMPLE_W'(SAMPLE_MAX))
            s = SAMPLE_W'($urandom_range(SAMPLE_MAX, int'(thr_right) + 1));
        end
        SYM_LEFT: s = SAMPLE_W'($urandom_range(int'(thr_left), 0));
        default: begin
          if (thr_left < thr_right)
            s = SAMPLE_W'($urandom_range(int'(thr_right), int'(thr_left) + 1));
        end
      endcase
      queue_tick(s, b);
    end
  endfunction

  // Mostly runs long enough to confirm, some cut short, some pure noise
  function automatic void add_random_runs(int n);
    int   added;
    int   len;
    int   hold;
    sym_t c;
    added = 0;
    while (added < n) begin
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) queue_tick(SAMPLE_W'($urandom), 1'($urandom));
      end else begin
        c = sym_t'($urandom_range(0, 3));
        hold = (c == SYM_NEUTRAL) ? int'(ticks_neutral) : int'(ticks_confirm);
        if (hold > 24) hold = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) len = $urandom_range(1, hold + 2);
        else len = hold + $urandom_range(2, 6);
        if (c == SYM_ATTACK && $urandom_range(0, 1) == 1) len += int'(ticks_holdoff);
        add_run(c, len);
      end
      added += len;
    end
  endfunction

  // Called at a falling edge; drives one register write
  task automatic set_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  task automatic configure(logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] l,
                           logic [TICKS_W-1:0] c, logic [TICKS_W-1:0] n,
                           logic [TICKS_W-1:0] h);
    set_register(CFG_RIGHT_THR, CFG_DATA_W'(r));
    set_register(CFG_LEFT_THR, CFG_DATA_W'(l));
    set_register(CFG_CONFIRM, CFG_DATA_W'(c));
    set_register(CFG_NEUTRAL_CFM, CFG_DATA_W'(n));
    set_register(CFG_HOLDOFF, CFG_DATA_W'(h));
    cfg_write <= 1'b0;
  endtask

  // Wait until every queued tick is taken and every result has been checked
  task automatic settle();
    do @(negedge clk);
    while (ticks_taken != ticks_queued || expected_reports.size() != 0);
  endtask

  // Input driver: hold a transaction until taken, insert idle bursts between
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accept) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_data  <= pending_ticks.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: stall in random bursts
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: track register writes, predict on input, check on output
  always @(posedge clk) begin
    out_item_t want;
    in_accept = 1'b0;
    if (!rst) begin
      if (cfg_write) apply_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        expected_reports.push_back(advance_debouncer(in_data));
        ticks_taken++;
        in_accept = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("%0t: result with nothing pending: %s", $realtime, show(out_data));
        end else begin
          want = expected_reports.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
              $display("%0t: mismatch expected %s", $realtime, show(want));
              $display("%0t:          actual   %s", $realtime, show(out_data));
            end
          end
        end
      end
      // watchdog on cycles without any transaction
      if (in_accept || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed at reset settings: threshold edges, each press, attack resume
    queue_tick(SAMPLE_W'(SAMPLE_MAX), 1'b0);
    queue_tick(12'd4051, 1'b0);
    queue_tick(12'd0, 1'b0);
    queue_tick(12'd4050, 1'b0);
    queue_tick(12'd2000, 1'b0);
    queue_tick(12'd0, 1'b0);
    queue_tick(12'd2001, 1'b0);
    queue_tick(12'd2001, 1'b0);
    queue_tick(SAMPLE_W'(SAMPLE_MAX), 1'b1);
    queue_tick(12'd0, 1'b1);
    queue_tick(12'd1234, 1'b1);
    queue_tick(12'd2222, 1'b1);
    queue_tick(12'd2001, 1'b0);
    add_run(SYM_ATTACK, 16);
    add_run(SYM_RIGHT, 3);
    add_random_runs(60);
    settle();

    configure(12'd3000, 12'd1000, 16'd2, 16'd3, 16'd2);
    add_random_runs(60);
    settle();

    // Nothing is right, only zero is left, every wait confirms at once
    configure(SAMPLE_W'(SAMPLE_MAX), 12'd0, 16'd0, 16'd0, 16'd0);
    add_random_runs(50);
    settle();

    // Overlapping thresholds
    configure(12'd0, SAMPLE_W'(SAMPLE_MAX), 16'd1, 16'd1, 16'd1);
    add_random_runs(50);
    settle();

    // Long hold-off and neutral wait
    calm = 1'b1;
    configure(12'd2500, 12'd1500, 16'd0, TICKS_W'(LONG_WAIT), TICKS_W'(LONG_WAIT));
    add_run(SYM_ATTACK, 3);
    add_run(SYM_LEFT, 1);
    add_run(SYM_NEUTRAL, 2 * LONG_WAIT + 10);
    add_run(SYM_LEFT, 3);
    settle();

    // Long confirm wait
    configure(12'd4000, 12'd100, TICKS_W'(LONG_WAIT), 16'd5, 16'd3);
    add_run(SYM_LEFT, 4);
    add_run(SYM_RIGHT, LONG_WAIT + 5);
    add_run(SYM_NEUTRAL, 10);
    settle();

    calm = 1'b0;
    configure(12'd3500, 12'd500, 16'd3, 16'd4, 16'd5);
    add_random_runs(40);
    settle();

    // Closing stretch with no idling
    calm = 1'b1;
    add_random_runs(100);
    settle();
    repeat (4) @(negedge clk);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
